// ===== design/tbp_pkg.sv =====
// shared types and constants for the tournament branch predictor
// no dependencies

package tbp_pkg;

   typedef enum logic [0:0] {
      KIND_PREDICT = 1'b0,
      KIND_UPDATE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] pc;
      logic        conditional;
      logic        taken;
   } request_type;

   localparam int PC_LOCAL_LSB  = 2;
   localparam int PC_GLOBAL_LSB = 12;

endpackage

// ===== design/tbp_front.sv =====
// front part: accepts requests into a two-entry queue
// depends on tbp_pkg

module tbp_front
   import tbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  request_type req_data,
   output logic        q_valid,
   input  logic        q_pop,
   output request_type q_data
);

   request_type  buf_ff [2];
   request_type  buf_in [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (q_pop && q_valid) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         buf_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/tbp_back.sv =====
// back part: table reads, prediction and update sequencer with clearing pass
// depends on tbp_pkg

module tbp_back
   import tbp_pkg::*;
#(
   parameter int LOCAL_ENTRIES      = 1024,
   parameter int LOCAL_HISTORY_BITS = 10,
   parameter int GLOBAL_INDEX_BITS  = 12,
   parameter int COUNTER_BITS       = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_pop,
   input  request_type q_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_prediction
);

   localparam int LB = $clog2(LOCAL_ENTRIES);
   localparam int HB = LOCAL_HISTORY_BITS;
   localparam int GB = GLOBAL_INDEX_BITS;
   localparam int CB = COUNTER_BITS;
   localparam int MB = (LB > HB) ? ((LB > GB) ? LB : GB) : ((HB > GB) ? HB : GB);
   localparam logic [CB-1:0] CMAX  = {CB{1'b1}};
   localparam logic [CB-1:0] CHALF = CMAX >> 1;
   localparam logic [MB:0]   CLR_N = (MB+1)'(1) << MB;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HIST, S_READ, S_DONE, S_OUT
   } state_type;

   logic [HB-1:0] lhist_mem [LOCAL_ENTRIES];
   logic [CB-1:0] lctr_mem  [2**HB];
   logic [CB-1:0] gctr_mem  [2**GB];
   logic [CB-1:0] chc_mem   [2**GB];

   state_type     state_ff;
   logic [MB:0]   clr_ff;
   request_type   req_ff;
   logic [LB-1:0] ls_ff;
   logic [GB-1:0] gs_ff;
   logic [HB-1:0] hist_ff;
   logic [CB-1:0] lc_ff, gc_ff, cc_ff;
   logic [GB-1:0] path_ff;
   logic          ll_ff, lg_ff, lf_ff;

   function automatic logic [CB-1:0] step(logic [CB-1:0] c, logic up);
      if (up) return (c == CMAX) ? c : c + 1'b1;
      return (c == '0) ? c : c - 1'b1;
   endfunction

   logic lp, gp, fp;
   always_comb begin
      lp = lc_ff > CHALF;
      gp = gc_ff > CHALF;
      fp = lp;
      if (lp != gp) fp = (cc_ff > CHALF) ? gp : lp;
   end

   assign q_pop          = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_prediction = lf_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         if (clr_ff < (MB+1)'(LOCAL_ENTRIES)) lhist_mem[clr_ff[LB-1:0]] <= '0;
         if (clr_ff < (MB+1)'(2**HB))     lctr_mem[clr_ff[HB-1:0]]  <= '0;
         if (clr_ff < (MB+1)'(2**GB)) begin
            gctr_mem[clr_ff[GB-1:0]] <= '0;
            chc_mem[clr_ff[GB-1:0]]  <= '0;
         end
      end
      if (state_ff == S_IDLE) begin
         req_ff <= q_data;
         ls_ff  <= q_data.pc[PC_LOCAL_LSB +: LB];
         gs_ff  <= q_data.pc[PC_GLOBAL_LSB +: GB] ^ path_ff;
      end
      if (state_ff == S_HIST) hist_ff <= lhist_mem[ls_ff];
      if (state_ff == S_READ) begin
         lc_ff <= lctr_mem[hist_ff];
         gc_ff <= gctr_mem[gs_ff];
         cc_ff <= chc_mem[gs_ff];
      end
      if (state_ff == S_DONE && req_ff.kind == KIND_UPDATE) begin
         lctr_mem[hist_ff] <= step(lc_ff, req_ff.taken);
         gctr_mem[gs_ff]   <= step(gc_ff, req_ff.taken);
         if (ll_ff != lg_ff) chc_mem[gs_ff] <= step(cc_ff, ll_ff != req_ff.taken);
         lhist_mem[ls_ff]  <= {hist_ff[HB-2:0], req_ff.taken};
      end
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         path_ff  <= '0;
         ll_ff    <= 1'b1;
         lg_ff    <= 1'b1;
         lf_ff    <= 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_N - 1'b1) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid) state_ff <= S_HIST;
            S_HIST: state_ff <= S_READ;
            S_READ: state_ff <= S_DONE;
            S_DONE: begin
               if (req_ff.kind == KIND_UPDATE) begin
                  path_ff  <= {path_ff[GB-2:0], req_ff.taken};
                  state_ff <= S_IDLE;
               end else begin
                  if (req_ff.conditional) begin
                     ll_ff <= lp;
                     lg_ff <= gp;
                     lf_ff <= fp;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== design/tournament_branch_predictor.sv =====
// tournament branch predictor top level: request queue and table sequencer
// depends on tbp_pkg, tbp_front, tbp_back
// a prediction passes through the queue register and the S_HIST, S_READ and S_DONE states before S_OUT shows it
// requests are handled one at a time: a new one is taken only in S_IDLE, after the serial history
// read, counter read and write-back on single-port tables; a prediction also waits in S_OUT while rsp_stall is high
// reset: synchronous; a clearing pass over 4096 addresses by default zeroes the tables

module tournament_branch_predictor
   import tbp_pkg::*;
#(
   parameter int LOCAL_ENTRIES      = 1024,
   parameter int LOCAL_HISTORY_BITS = 10,
   parameter int GLOBAL_INDEX_BITS  = 12,
   parameter int COUNTER_BITS       = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_pc,
   input  logic        req_conditional,
   input  logic        req_taken,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_prediction
);

   request_type req_data, q_data;
   logic        q_valid, q_pop;

   assign req_data = '{kind: req_kind, pc: req_pc,
                       conditional: req_conditional, taken: req_taken};

   tbp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   tbp_back #(
      .LOCAL_ENTRIES(LOCAL_ENTRIES), .LOCAL_HISTORY_BITS(LOCAL_HISTORY_BITS),
      .GLOBAL_INDEX_BITS(GLOBAL_INDEX_BITS), .COUNTER_BITS(COUNTER_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .rsp_valid, .rsp_stall, .rsp_prediction
   );

endmodule

// ===== tb/tournament_branch_predictor_tb.sv =====
// testbench for the tournament branch predictor: random and directed prediction and
// outcome requests, checked against a behavioral predictor kept in a scoreboard class
// depends on tbp_pkg and tournament_branch_predictor
`timescale 1ns / 100ps

module tournament_branch_predictor_tb;
   import tbp_pkg::*;

   class prediction_board;
      logic [9:0]  local_hist [1024];
      logic [2:0]  local_ctr [1024];
      logic [2:0]  global_ctr [4096];
      logic [2:0]  choice_ctr [4096];
      logic [11:0] path_hist;
      logic        last_local, last_global, last_final;
      logic        pending [$];
      int          errors;
      int          checked;

      function new();
         foreach (local_hist[i]) local_hist[i] = '0;
         foreach (local_ctr[i]) local_ctr[i] = '0;
         foreach (global_ctr[i]) global_ctr[i] = '0;
         foreach (choice_ctr[i]) choice_ctr[i] = '0;
         path_hist = '0;
         last_local = 1'b1;
         last_global = 1'b1;
         last_final = 1'b1;
         errors = 0;
         checked = 0;
      endfunction

      function logic [2:0] bump(logic [2:0] c, logic up);
         if (up) return (c == 3'd7) ? c : c + 3'd1;
         return (c == 3'd0) ? c : c - 3'd1;
      endfunction

      function void note_request(kind_type kind, logic [31:0] pc, logic cond, logic taken);
         logic [9:0]  slot;
         logic [9:0]  hist;
         logic [11:0] gslot;
         logic        lp, gp;
         slot = pc[11:2];
         hist = local_hist[slot];
         gslot = pc[23:12] ^ path_hist;
         if (kind == KIND_PREDICT) begin
            if (cond) begin
               lp = local_ctr[hist] > 3'd3;
               gp = global_ctr[gslot] > 3'd3;
               last_final = (lp != gp && choice_ctr[gslot] > 3'd3) ? gp : lp;
               last_local = lp;
               last_global = gp;
            end
            pending.push_back(last_final);
         end else begin
            local_ctr[hist] = bump(local_ctr[hist], taken);
            global_ctr[gslot] = bump(global_ctr[gslot], taken);
            if (last_local != last_global)
               choice_ctr[gslot] = bump(choice_ctr[gslot], last_local != taken);
            local_hist[slot] = {hist[8:0], taken};
            path_hist = {path_hist[10:0], taken};
         end
      endfunction

      function void check_result(logic prediction);
         logic want;
         checked++;
         if (pending.size() == 0) begin
            $error("prediction %0b arrived with none expected", prediction);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (prediction !== want) begin
            $error("prediction: expected %0b, actual %0b", want, prediction);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [31:0] req_pc;
   logic        req_conditional;
   logic        req_taken;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_prediction;

   prediction_board board;
   int          cycles;
   int          sent;
   bit          stall_free;

   tournament_branch_predictor DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL tournament_branch_predictor");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_prediction);

   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_free) gap = 0;
         else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send(kind_type kind, logic [31:0] pc, logic cond, logic taken, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pc <= pc;
      req_conditional <= cond;
      req_taken <= taken;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(kind, pc, cond, taken);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      logic [31:0] hot_pc [8];
      logic [31:0] pc;
      int          i, j, gap;
      board = new();
      cycles = 0;
      sent = 0;
      stall_free = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_PREDICT;
      req_pc = '0;
      req_conditional = 1'b0;
      req_taken = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: unconditional before any prediction, update before prediction
      send(KIND_PREDICT, 32'h0, 1'b0, 1'b0, 0);
      send(KIND_UPDATE, 32'hffff_ffff, 1'b1, 1'b1, 0);
      send(KIND_PREDICT, 32'hffff_ffff, 1'b1, 1'b0, 0);
      send(KIND_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 0);
      for (i = 0; i < 6; i++) send(KIND_UPDATE, 32'h0000_1004, 1'b0, 1'b1, 0);
      send(KIND_PREDICT, 32'h0000_1004, 1'b1, 1'b0, 0);
      send(KIND_PREDICT, 32'hdead_beef, 1'b0, 1'b1, 0);
      for (i = 0; i < 9; i++) send(KIND_UPDATE, 32'h00ff_fffc, 1'b0, 1'b0, 0);
      send(KIND_PREDICT, 32'h00ff_fffc, 1'b1, 1'b0, 0);
      send(KIND_PREDICT, 32'hff00_0003, 1'b1, 1'b0, 0);
      drain();

      for (i = 0; i < 8; i++) hot_pc[i] = $urandom();
      for (i = 0; i < 1700; i++) begin
         if (i == 700) drain();
         stall_free = (i >= 1000 && i < 1150);
         gap = (i >= 1200 && i < 1350) ? 0 :
               (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
         j = $urandom_range(0, 9);
         pc = (j < 8) ? hot_pc[j] : $urandom();
         if ($urandom_range(0, 3) != 0) begin
            // predict then resolve the same branch, with a periodic outcome for hot branches 0 to 3
            send(KIND_PREDICT, pc, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), gap);
            send(KIND_UPDATE, pc, 1'($urandom_range(0, 1)),
                 (j < 4) ? (i % (j + 2) != 0) : 1'($urandom_range(0, 1)), 0);
            i++;
         end else begin
            send(kind_type'($urandom_range(0, 1)), pc, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), gap);
         end
      end
      drain();

      $display("covered %0d requests and %0d predictions under random gaps and stalls",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS tournament_branch_predictor");
      end else begin
         $display("FAIL tournament_branch_predictor");
      end
      $finish;
   end

endmodule
